// ===== hw/rtl/dhcpo_pkg.sv =====
package dhcpo_pkg;

	// Fixed field widths
	localparam int BYTE_W   = 8;
	localparam int LEN_IN_W = 10;
	localparam int STATUS_W = 3;
	localparam int WORD_W   = 32;

	// Magic cookie at the head of the options field
	localparam logic [WORD_W-1:0] COOKIE_MAGIC = 32'h6382_5363;
	localparam int                COOKIE_BYTES = 4;

	// Option codes
	localparam logic [BYTE_W-1:0] OPT_PAD      = 8'd0;
	localparam logic [BYTE_W-1:0] OPT_SUBNET   = 8'd1;
	localparam logic [BYTE_W-1:0] OPT_ROUTER   = 8'd3;
	localparam logic [BYTE_W-1:0] OPT_DNS      = 8'd6;
	localparam logic [BYTE_W-1:0] OPT_LEASE    = 8'd51;
	localparam logic [BYTE_W-1:0] OPT_MSG_TYPE = 8'd53;
	localparam logic [BYTE_W-1:0] OPT_SERVER   = 8'd54;
	localparam logic [BYTE_W-1:0] OPT_END      = 8'd255;

	// Result status codes (3 = code without length is reserved, never raised)
	localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
	localparam logic [STATUS_W-1:0] ST_SHORT      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_COOKIE = 3'd2;
	localparam logic [STATUS_W-1:0] ST_OVERRUN    = 3'd4;

	// Walk phase
	typedef enum logic [2:0] {
		PH_COOKIE = 3'd0,
		PH_CODE   = 3'd1,
		PH_LEN    = 3'd2,
		PH_VALUE  = 3'd3,
		PH_DONE   = 3'd4
	} phase_t;

	// One parse result
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [BYTE_W-1:0]   msg_type;
		logic [WORD_W-1:0]   netmask;
		logic [WORD_W-1:0]   router_addr;
		logic [WORD_W-1:0]   dns_addr;
		logic [WORD_W-1:0]   server_id;
		logic [WORD_W-1:0]   lease_seconds;
	} result_t;

	// Code kept for capture, or pad when the code is not captured or the length rule fails
	function automatic logic [BYTE_W-1:0] capture_code(input logic [BYTE_W-1:0] code,
			input logic [BYTE_W-1:0] len);
		logic [BYTE_W-1:0] kept;
		kept = OPT_PAD;
		unique case (code) inside
			OPT_MSG_TYPE: kept = (len == 8'd1) ? code : OPT_PAD;
			OPT_SUBNET, OPT_SERVER, OPT_LEASE: kept = (len == 8'd4) ? code : OPT_PAD;
			OPT_ROUTER, OPT_DNS: kept = (len >= 8'd4) ? code : OPT_PAD;
			default: kept = OPT_PAD;
		endcase
		return kept;
	endfunction

endpackage

// ===== hw/rtl/dhcpo_parse.sv =====
module dhcpo_parse #(
	parameter int MAX_FIELD_BYTES = 512
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             take,
	input  logic [dhcpo_pkg::BYTE_W-1:0]     data_byte,
	input  logic [dhcpo_pkg::LEN_IN_W-1:0]   options_length,
	output logic                             last,
	output dhcpo_pkg::result_t               result
);

	localparam int PosW    = $clog2(MAX_FIELD_BYTES);
	localparam int LenW    = $clog2(MAX_FIELD_BYTES + 1);
	localparam int LenExtW = dhcpo_pkg::LEN_IN_W + 1;
	localparam int SumW    = $clog2(MAX_FIELD_BYTES + 257);
	localparam int BW      = dhcpo_pkg::BYTE_W;
	localparam int WW      = dhcpo_pkg::WORD_W;

	dhcpo_pkg::phase_t phase_q, phase_d;
	logic [PosW-1:0]   pos_q;
	logic [WW-1:0]     cookie_q, cookie_d;
	logic [BW-1:0]     code_q, code_d;
	logic [BW-1:0]     left_q, left_d;
	logic [WW-1:0]     val_q, val_d;
	logic [2:0]        taken_q, taken_d;
	logic [dhcpo_pkg::STATUS_W-1:0] err_q, err_d;
	logic [BW-1:0]     mt_q, mt_d;
	logic [WW-1:0]     subnet_q, subnet_d;
	logic [WW-1:0]     router_q, router_d;
	logic [WW-1:0]     dns_q, dns_d;
	logic [WW-1:0]     server_q, server_d;
	logic [WW-1:0]     lease_q, lease_d;

	logic [LenExtW-1:0] len_ext, len_clip;
	logic [LenW-1:0]    len_c;
	logic [SumW-1:0]    len_s, pos_s, byte_s;

	// Clamp the field length to 1..MAX_FIELD_BYTES
	assign len_ext  = {1'b0, options_length};
	assign len_clip = (options_length == '0) ? LenExtW'(1) :
		(len_ext > LenExtW'(MAX_FIELD_BYTES)) ? LenExtW'(MAX_FIELD_BYTES) : len_ext;
	assign len_c    = len_clip[LenW-1:0];

	assign len_s  = SumW'(len_c);
	assign pos_s  = SumW'(pos_q);
	assign byte_s = SumW'(data_byte);

	assign last = (pos_s + SumW'(1)) >= len_s;

	// Walk step for the current byte
	always_comb begin
		phase_d  = phase_q;
		cookie_d = cookie_q;
		code_d   = code_q;
		left_d   = left_q;
		val_d    = val_q;
		taken_d  = taken_q;
		err_d    = err_q;
		mt_d     = mt_q;
		subnet_d = subnet_q;
		router_d = router_q;
		dns_d    = dns_q;
		server_d = server_q;
		lease_d  = lease_q;

		unique case (phase_q)
			dhcpo_pkg::PH_COOKIE: begin
				cookie_d = {cookie_q[WW-BW-1:0], data_byte};
				if (pos_q >= PosW'(dhcpo_pkg::COOKIE_BYTES - 1)) begin
					if (cookie_d != dhcpo_pkg::COOKIE_MAGIC) begin
						err_d   = dhcpo_pkg::ST_BAD_COOKIE;
						phase_d = dhcpo_pkg::PH_DONE;
					end else begin
						phase_d = dhcpo_pkg::PH_CODE;
					end
				end
			end
			dhcpo_pkg::PH_CODE: begin
				// a code needs at least two more bytes behind it
				if ((pos_s + SumW'(2)) < len_s) begin
					if (data_byte == dhcpo_pkg::OPT_END) begin
						phase_d = dhcpo_pkg::PH_DONE;
					end else if (data_byte != dhcpo_pkg::OPT_PAD) begin
						code_d  = data_byte;
						phase_d = dhcpo_pkg::PH_LEN;
					end
				end else begin
					phase_d = dhcpo_pkg::PH_DONE;
				end
			end
			dhcpo_pkg::PH_LEN: begin
				if ((pos_s + SumW'(1) + byte_s) > len_s) begin
					err_d   = dhcpo_pkg::ST_OVERRUN;
					phase_d = dhcpo_pkg::PH_DONE;
				end else if (data_byte == '0) begin
					phase_d = dhcpo_pkg::PH_CODE;
				end else begin
					code_d  = dhcpo_pkg::capture_code(code_q, data_byte);
					left_d  = data_byte;
					val_d   = '0;
					taken_d = '0;
					phase_d = dhcpo_pkg::PH_VALUE;
				end
			end
			dhcpo_pkg::PH_VALUE: begin
				// assemble up to four value bytes, first byte most significant
				if (!taken_q[2]) begin
					val_d   = {val_q[WW-BW-1:0], data_byte};
					taken_d = taken_q + 3'd1;
					if (taken_d == 3'd4 ||
							(code_q == dhcpo_pkg::OPT_MSG_TYPE && taken_d == 3'd1)) begin
						case (code_q)
							dhcpo_pkg::OPT_MSG_TYPE: mt_d     = val_d[BW-1:0];
							dhcpo_pkg::OPT_SUBNET:   subnet_d = val_d;
							dhcpo_pkg::OPT_ROUTER:   router_d = val_d;
							dhcpo_pkg::OPT_DNS:      dns_d    = val_d;
							dhcpo_pkg::OPT_SERVER:   server_d = val_d;
							dhcpo_pkg::OPT_LEASE:    lease_d  = val_d;
							default: ;
						endcase
					end
				end
				left_d = left_q - 8'd1;
				if (left_d == '0) begin
					phase_d = dhcpo_pkg::PH_CODE;
				end
			end
			dhcpo_pkg::PH_DONE: ;
			default: phase_d = dhcpo_pkg::PH_DONE;
		endcase
	end

	// Result seen on the last byte
	always_comb begin
		result.status        = (len_c < LenW'(dhcpo_pkg::COOKIE_BYTES)) ?
			dhcpo_pkg::ST_SHORT : err_d;
		result.msg_type      = mt_d;
		result.netmask       = subnet_d;
		result.router_addr   = router_d;
		result.dns_addr      = dns_d;
		result.server_id     = server_d;
		result.lease_seconds = lease_d;
	end

	// Walk state; everything clears after the last byte of a field
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= dhcpo_pkg::PH_COOKIE;
			pos_q    <= '0;
			cookie_q <= '0;
			code_q   <= '0;
			left_q   <= '0;
			val_q    <= '0;
			taken_q  <= '0;
			err_q    <= dhcpo_pkg::ST_OK;
			mt_q     <= '0;
			subnet_q <= '0;
			router_q <= '0;
			dns_q    <= '0;
			server_q <= '0;
			lease_q  <= '0;
		end else if (take) begin
			if (last) begin
				phase_q  <= dhcpo_pkg::PH_COOKIE;
				pos_q    <= '0;
				cookie_q <= '0;
				code_q   <= '0;
				left_q   <= '0;
				val_q    <= '0;
				taken_q  <= '0;
				err_q    <= dhcpo_pkg::ST_OK;
				mt_q     <= '0;
				subnet_q <= '0;
				router_q <= '0;
				dns_q    <= '0;
				server_q <= '0;
				lease_q  <= '0;
			end else begin
				phase_q  <= phase_d;
				pos_q    <= pos_q + PosW'(1);
				cookie_q <= cookie_d;
				code_q   <= code_d;
				left_q   <= left_d;
				val_q    <= val_d;
				taken_q  <= taken_d;
				err_q    <= err_d;
				mt_q     <= mt_d;
				subnet_q <= subnet_d;
				router_q <= router_d;
				dns_q    <= dns_d;
				server_q <= server_d;
				lease_q  <= lease_d;
			end
		end
	end

endmodule

// ===== hw/rtl/dhcp_option_tlv_parser.sv =====
// DHCP options field parser.
// Input channel (in_valid / in_stall): one byte of the options field per item,
// cookie first, with the field's total length on every item. Lengths of 0 are
// treated as 1 and lengths above MAX_FIELD_BYTES as MAX_FIELD_BYTES.
// Output channel (out_valid / out_stall): one item per field, with a status and
// the captured message type, subnet mask, router, DNS, server id and lease time.
// Throughput: one byte per clock unless stalled; each byte goes through a single walk step
// between the parse state registers and the result register.
// Latency: the result is valid the cycle after the field's last byte is taken.
// When the receiver stalls, the result holds in the output register; bytes that
// do not end a field are still taken, and only a field's last byte is stalled
// until the waiting result leaves.
// Reset (arst_n low) clears the walk to the start of a field and empties the
// output register; no result is pending afterwards.
module dhcp_option_tlv_parser #(
	parameter int MAX_FIELD_BYTES = 512
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [dhcpo_pkg::BYTE_W-1:0]         data_byte,
	input  logic [dhcpo_pkg::LEN_IN_W-1:0]       options_length,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [dhcpo_pkg::STATUS_W-1:0]       status,
	output logic [dhcpo_pkg::BYTE_W-1:0]         msg_type,
	output logic [dhcpo_pkg::WORD_W-1:0]         netmask,
	output logic [dhcpo_pkg::WORD_W-1:0]         router_addr,
	output logic [dhcpo_pkg::WORD_W-1:0]         dns_addr,
	output logic [dhcpo_pkg::WORD_W-1:0]         server_id,
	output logic [dhcpo_pkg::WORD_W-1:0]         lease_seconds
);

	logic               take;
	logic               last;
	logic               out_valid_q;
	dhcpo_pkg::result_t result;
	dhcpo_pkg::result_t res_q;

	// Only a last byte needs the output slot
	assign in_stall = out_valid_q & out_stall & last;
	assign take     = in_valid & ~in_stall;

	dhcpo_parse #(
		.MAX_FIELD_BYTES(MAX_FIELD_BYTES)
	) u_parse (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (take),
		.data_byte     (data_byte),
		.options_length(options_length),
		.last          (last),
		.result        (result)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take & last) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take & last) begin
			res_q <= result;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = res_q.status;
	assign msg_type      = res_q.msg_type;
	assign netmask       = res_q.netmask;
	assign router_addr   = res_q.router_addr;
	assign dns_addr      = res_q.dns_addr;
	assign server_id     = res_q.server_id;
	assign lease_seconds = res_q.lease_seconds;

endmodule

// ===== tb/dhcp_option_tlv_parser_tb.sv =====
module dhcp_option_tlv_parser_tb;

	localparam int BW = dhcpo_pkg::BYTE_W;
	localparam int LW = dhcpo_pkg::LEN_IN_W;
	localparam int SW = dhcpo_pkg::STATUS_W;
	localparam int WW = dhcpo_pkg::WORD_W;

	localparam int MAX_BYTES    = 512;
	localparam int RANDOM_BYTES = 380;
	localparam int WIDE_BYTES   = 40;
	localparam int DRAIN_CYCLES = 10;
	localparam int CYCLE_LIMIT  = 300000;

	// Cookie bytes in wire order
	localparam logic [WW-1:0] MAGIC = dhcpo_pkg::COOKIE_MAGIC;
	localparam logic [BW-1:0] CK_0 = MAGIC[31:24];
	localparam logic [BW-1:0] CK_1 = MAGIC[23:16];
	localparam logic [BW-1:0] CK_2 = MAGIC[15:8];
	localparam logic [BW-1:0] CK_3 = MAGIC[7:0];

	typedef enum int {
		FIELD_GOOD,
		FIELD_CORRUPT_COOKIE,
		FIELD_NOISE
	} field_form_t;

	logic          clk;
	logic          arst_n;
	logic          in_valid;
	logic          in_stall;
	logic [BW-1:0] data_byte;
	logic [LW-1:0] options_length;
	logic          out_valid;
	logic          out_stall;
	logic [SW-1:0] status;
	logic [BW-1:0] msg_type;
	logic [WW-1:0] netmask;
	logic [WW-1:0] router_addr;
	logic [WW-1:0] dns_addr;
	logic [WW-1:0] server_id;
	logic [WW-1:0] lease_seconds;

	dhcp_option_tlv_parser #(.MAX_FIELD_BYTES(MAX_BYTES)) i_dut (.*);

	// Walk state of the predictor
	logic [LW-1:0]     walk_pos;
	dhcpo_pkg::phase_t walk_phase;
	logic [WW-1:0]     cookie_acc;
	logic [BW-1:0]     opt_code;
	logic [BW-1:0]     opt_left;
	logic [WW-1:0]     opt_value;
	int                opt_taken;
	logic [SW-1:0]     walk_err;
	logic [BW-1:0]     seen_msg_type;
	logic [WW-1:0]     seen_subnet;
	logic [WW-1:0]     seen_router;
	logic [WW-1:0]     seen_dns;
	logic [WW-1:0]     seen_server;
	logic [WW-1:0]     seen_lease;

	dhcpo_pkg::result_t pending_results[$];
	logic [BW-1:0]      field_bytes[$];

	bit src_calm;
	bit sink_calm;
	int bytes_sent;
	int fields_sent;
	int results_checked;
	int mismatches;
	int cycle_count;
	int status_count[8];

	// Advance the options walk by one byte; returns 1 when the field ends
	function automatic bit walk_options_byte(input logic [BW-1:0] b,
			input logic [LW-1:0] len_word, output dhcpo_pkg::result_t res);
		int len;
		int p;
		logic [BW-1:0] keep;
		res = '0;
		len = int'(len_word);
		if (len == 0) len = 1;
		if (len > MAX_BYTES) len = MAX_BYTES;
		p = int'(walk_pos);

		// start of a field wipes everything captured before
		if (p == 0) begin
			walk_phase    = dhcpo_pkg::PH_COOKIE;
			cookie_acc    = '0;
			opt_code      = '0;
			opt_left      = '0;
			opt_value     = '0;
			opt_taken     = 0;
			walk_err      = dhcpo_pkg::ST_OK;
			seen_msg_type = '0;
			seen_subnet   = '0;
			seen_router   = '0;
			seen_dns      = '0;
			seen_server   = '0;
			seen_lease    = '0;
		end

		case (walk_phase)
			dhcpo_pkg::PH_COOKIE: begin
				cookie_acc = {cookie_acc[23:0], b};
				if (p + 1 >= dhcpo_pkg::COOKIE_BYTES) begin
					if (cookie_acc == dhcpo_pkg::COOKIE_MAGIC) begin
						walk_phase = dhcpo_pkg::PH_CODE;
					end else begin
						walk_err   = dhcpo_pkg::ST_BAD_COOKIE;
						walk_phase = dhcpo_pkg::PH_DONE;
					end
				end
			end
			dhcpo_pkg::PH_CODE: begin
				// a code needs room for its length byte and one more
				if (p + 2 < len) begin
					if (b == dhcpo_pkg::OPT_END) begin
						walk_phase = dhcpo_pkg::PH_DONE;
					end else if (b != dhcpo_pkg::OPT_PAD) begin
						opt_code   = b;
						walk_phase = dhcpo_pkg::PH_LEN;
					end
				end else begin
					walk_phase = dhcpo_pkg::PH_DONE;
				end
			end
			dhcpo_pkg::PH_LEN: begin
				if (p + 1 + int'(b) > len) begin
					walk_err   = dhcpo_pkg::ST_OVERRUN;
					walk_phase = dhcpo_pkg::PH_DONE;
				end else if (b == 8'd0) begin
					walk_phase = dhcpo_pkg::PH_CODE;
				end else begin
					// options with the wrong length are walked but not kept
					keep = dhcpo_pkg::OPT_PAD;
					case (opt_code)
						dhcpo_pkg::OPT_MSG_TYPE: if (b == 8'd1) keep = opt_code;
						dhcpo_pkg::OPT_SUBNET, dhcpo_pkg::OPT_SERVER,
						dhcpo_pkg::OPT_LEASE: if (b == 8'd4) keep = opt_code;
						dhcpo_pkg::OPT_ROUTER,
						dhcpo_pkg::OPT_DNS: if (b >= 8'd4) keep = opt_code;
						default: keep = dhcpo_pkg::OPT_PAD;
					endcase
					opt_code   = keep;
					opt_left   = b;
					opt_value  = '0;
					opt_taken  = 0;
					walk_phase = dhcpo_pkg::PH_VALUE;
				end
			end
			dhcpo_pkg::PH_VALUE: begin
				if (opt_taken < 4) begin
					opt_value = {opt_value[23:0], b};
					opt_taken++;
					if (opt_taken == 4 ||
							(opt_code == dhcpo_pkg::OPT_MSG_TYPE && opt_taken == 1)) begin
						case (opt_code)
							dhcpo_pkg::OPT_MSG_TYPE: seen_msg_type = opt_value[7:0];
							dhcpo_pkg::OPT_SUBNET:   seen_subnet   = opt_value;
							dhcpo_pkg::OPT_ROUTER:   seen_router   = opt_value;
							dhcpo_pkg::OPT_DNS:      seen_dns      = opt_value;
							dhcpo_pkg::OPT_SERVER:   seen_server   = opt_value;
							dhcpo_pkg::OPT_LEASE:    seen_lease    = opt_value;
							default: ;
						endcase
					end
				end
				opt_left = opt_left - 8'd1;
				if (opt_left == 8'd0) walk_phase = dhcpo_pkg::PH_CODE;
			end
			default: ;
		endcase

		if (p + 1 < len) begin
			walk_pos = LW'(p + 1);
			return 1'b0;
		end

		res.status        = (len < dhcpo_pkg::COOKIE_BYTES) ? dhcpo_pkg::ST_SHORT : walk_err;
		res.msg_type      = seen_msg_type;
		res.netmask       = seen_subnet;
		res.router_addr   = seen_router;
		res.dns_addr      = seen_dns;
		res.server_id     = seen_server;
		res.lease_seconds = seen_lease;
		walk_pos   = '0;
		walk_phase = dhcpo_pkg::PH_COOKIE;
		return 1'b1;
	endfunction

	// Drive one byte, wait for it to be taken, then predict
	task automatic send_byte(input logic [BW-1:0] b, input logic [LW-1:0] len_word);
		int gap;
		dhcpo_pkg::result_t res;
		gap = src_calm ? 0 : $urandom_range(0, 14);
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid       = 1'b1;
		data_byte      = b;
		options_length = len_word;
		do @(posedge clk); while (in_stall);
		if (walk_options_byte(b, len_word, res)) begin
			pending_results.push_back(res);
			status_count[res.status]++;
		end
		bytes_sent++;
		@(negedge clk);
	endtask

	// Send field_bytes; with wander set, every byte but the last carries a length at least as large
	task automatic send_field(input int len_val, input bit wander);
		int lw;
		for (int i = 0; i < field_bytes.size(); i++) begin
			lw = (wander && i != field_bytes.size() - 1) ? $urandom_range(len_val, 1023) : len_val;
			send_byte(field_bytes[i], LW'(lw));
		end
		fields_sent++;
	endtask

	// Fill field_bytes with a random field of the given length word
	task automatic build_field(input int len_val, input field_form_t form);
		int n;
		int pick;
		int olen;
		int style;
		logic [BW-1:0] code;
		n = (len_val == 0) ? 1 : (len_val > MAX_BYTES) ? MAX_BYTES : len_val;
		field_bytes.delete();
		if (form == FIELD_NOISE) begin
			while (field_bytes.size() < n) field_bytes.push_back(BW'($urandom));
			return;
		end
		field_bytes = '{CK_0, CK_1, CK_2, CK_3};
		if (form == FIELD_CORRUPT_COOKIE) begin
			pick = $urandom_range(0, 3);
			field_bytes[pick] = field_bytes[pick] ^ (8'h01 << $urandom_range(0, 7));
		end
		while (field_bytes.size() < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				field_bytes.push_back(dhcpo_pkg::OPT_PAD);
			end else if (pick < 11) begin
				// end marker, trailing garbage after it
				field_bytes.push_back(dhcpo_pkg::OPT_END);
				while (field_bytes.size() < n) field_bytes.push_back(BW'($urandom));
			end else begin
				if (pick < 85) begin
					case ($urandom_range(0, 5))
						0: begin code = dhcpo_pkg::OPT_MSG_TYPE; olen = 1; end
						1: begin code = dhcpo_pkg::OPT_SUBNET; olen = 4; end
						2: begin code = dhcpo_pkg::OPT_SERVER; olen = 4; end
						3: begin code = dhcpo_pkg::OPT_LEASE; olen = 4; end
						4: begin code = dhcpo_pkg::OPT_ROUTER; olen = 4 * $urandom_range(1, 3); end
						default: begin code = dhcpo_pkg::OPT_DNS; olen = 4 * $urandom_range(1, 3); end
					endcase
					if ($urandom_range(0, 4) == 0) olen = $urandom_range(0, 9);
				end else begin
					code = BW'($urandom_range(1, 254));
					olen = $urandom_range(0, 12);
				end
				field_bytes.push_back(code);
				field_bytes.push_back(BW'(olen));
				style = $urandom_range(0, 5);
				repeat (olen) begin
					if (style == 0) field_bytes.push_back(8'h00);
					else if (style == 1) field_bytes.push_back(8'hff);
					else field_bytes.push_back(BW'($urandom));
				end
			end
		end
		// cutting at the field length leaves overruns and dangling codes
		while (field_bytes.size() > n) void'(field_bytes.pop_back());
	endtask

	task automatic check_field(input string what, input logic [WW-1:0] want,
			input logic [WW-1:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0s mismatch on result %0d: expected %h, got %h",
					what, results_checked, want, got);
		end
	endtask

	// Fields shorter than the cookie, zero length, cookie only
	task automatic test_short_fields();
		field_bytes = '{CK_0};
		send_field(0, 1'b0);
		field_bytes = '{8'hff};
		send_field(1, 1'b0);
		field_bytes = '{CK_0, CK_1};
		send_field(2, 1'b0);
		field_bytes = '{CK_0, CK_1, CK_2};
		send_field(3, 1'b0);
		field_bytes = '{CK_0, CK_1, CK_2, CK_3};
		send_field(4, 1'b0);
	endtask

	task automatic test_bad_cookie();
		field_bytes = '{CK_0, CK_1, CK_2, 8'h62, dhcpo_pkg::OPT_MSG_TYPE, 8'h01, 8'h05,
			dhcpo_pkg::OPT_END};
		send_field(8, 1'b0);
	endtask

	// Every captured option with extreme values, then End and trailing bytes
	task automatic test_captures();
		field_bytes = '{CK_0, CK_1, CK_2, CK_3, dhcpo_pkg::OPT_PAD,
			dhcpo_pkg::OPT_MSG_TYPE, 8'h01, 8'hff,
			dhcpo_pkg::OPT_SUBNET, 8'h04, 8'hff, 8'hff, 8'hff, 8'h00,
			dhcpo_pkg::OPT_ROUTER, 8'h08, 8'hc0, 8'ha8, 8'h01, 8'h01,
			8'hc0, 8'ha8, 8'h01, 8'h02,
			dhcpo_pkg::OPT_DNS, 8'h04, 8'h08, 8'h08, 8'h04, 8'h04,
			dhcpo_pkg::OPT_SERVER, 8'h04, 8'h80, 8'h00, 8'h00, 8'h01,
			dhcpo_pkg::OPT_LEASE, 8'h04, 8'h00, 8'h01, 8'h51, 8'h80,
			dhcpo_pkg::OPT_END, 8'hff, dhcpo_pkg::OPT_MSG_TYPE};
		send_field(45, 1'b0);
	endtask

	// Wrong lengths are skipped, zero length, later copy wins, code too late to read
	task automatic test_bad_option_lengths();
		field_bytes = '{CK_0, CK_1, CK_2, CK_3,
			dhcpo_pkg::OPT_MSG_TYPE, 8'h02, 8'h01, 8'h02,
			dhcpo_pkg::OPT_SUBNET, 8'h03, 8'haa, 8'hbb, 8'hcc,
			dhcpo_pkg::OPT_LEASE, 8'h05, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05,
			dhcpo_pkg::OPT_ROUTER, 8'h00,
			dhcpo_pkg::OPT_MSG_TYPE, 8'h01, 8'h07,
			dhcpo_pkg::OPT_MSG_TYPE, 8'h01, 8'h02,
			dhcpo_pkg::OPT_DNS, 8'h04};
		send_field(30, 1'b0);
	endtask

	// Option running past the field end keeps what came before
	task automatic test_overrun();
		field_bytes = '{CK_0, CK_1, CK_2, CK_3,
			dhcpo_pkg::OPT_SUBNET, 8'h04, 8'hff, 8'hff, 8'hff, 8'hfe,
			dhcpo_pkg::OPT_ROUTER, 8'h09, 8'h0a, 8'h0b};
		send_field(14, 1'b0);
	endtask

	// Length word changing inside a field, both growing and cutting it short
	task automatic test_length_change();
		field_bytes = '{CK_0, CK_1, CK_2, CK_3, dhcpo_pkg::OPT_MSG_TYPE, 8'h01, 8'h03,
			dhcpo_pkg::OPT_END};
		send_field(8, 1'b1);
		field_bytes = '{CK_0, CK_1, CK_2, CK_3, dhcpo_pkg::OPT_PAD, dhcpo_pkg::OPT_MSG_TYPE};
		for (int i = 0; i < 6; i++) send_byte(field_bytes[i], (i == 5) ? 10'd3 : 10'd20);
		fields_sent++;
	endtask

	// Length words above the size limit on every byte but the last
	task automatic test_max_field();
		int lw;
		build_field(WIDE_BYTES, FIELD_GOOD);
		for (int i = 0; i < field_bytes.size(); i++) begin
			lw = (i != field_bytes.size() - 1) ?
				$urandom_range(MAX_BYTES + 1, 1023) : WIDE_BYTES;
			send_byte(field_bytes[i], LW'(lw));
		end
		fields_sent++;
	endtask

	task automatic test_random_fields();
		int start;
		int len_val;
		int pick;
		field_form_t form;
		start = bytes_sent;
		while (bytes_sent - start < RANDOM_BYTES) begin
			if ($urandom_range(0, 4) == 0) src_calm = !src_calm;
			pick = $urandom_range(0, 99);
			if (pick < 10) len_val = $urandom_range(0, 7);
			else if (pick < 95) len_val = $urandom_range(8, 48);
			else len_val = $urandom_range(49, 120);
			pick = $urandom_range(0, 99);
			if (pick < 80) form = FIELD_GOOD;
			else if (pick < 90) form = FIELD_CORRUPT_COOKIE;
			else form = FIELD_NOISE;
			build_field(len_val, form);
			send_field(len_val, $urandom_range(0, 11) == 0);
		end
		src_calm = 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: random stall before each result, with stall-free stretches
	initial begin
		int hold;
		out_stall = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 9) == 0) sink_calm = !sink_calm;
			hold = sink_calm ? 0 : $urandom_range(0, 14);
			out_stall = (hold != 0);
			repeat (hold) @(negedge clk);
			out_stall = 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	// Compare each result taken with the oldest prediction
	always @(posedge clk) begin : check_results
		dhcpo_pkg::result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d arrived with nothing expected", results_checked);
			end else begin
				want = pending_results.pop_front();
				check_field("status", WW'(want.status), WW'(status));
				check_field("msg_type", WW'(want.msg_type), WW'(msg_type));
				check_field("netmask", want.netmask, netmask);
				check_field("router_addr", want.router_addr, router_addr);
				check_field("dns_addr", want.dns_addr, dns_addr);
				check_field("server_id", want.server_id, server_id);
				check_field("lease_seconds", want.lease_seconds, lease_seconds);
			end
			results_checked++;
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still pending",
				cycle_count, pending_results.size());
			$display("dhcp_option_tlv_parser_tb: errors");
			$finish;
		end
	end

	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		data_byte      = '0;
		options_length = '0;
		walk_pos       = '0;
		walk_phase     = dhcpo_pkg::PH_COOKIE;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_short_fields();
		test_bad_cookie();
		test_captures();
		test_bad_option_lengths();
		test_overrun();
		test_length_change();
		test_max_field();
		test_random_fields();
		in_valid = 1'b0;

		// drain
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d option fields in %0d bytes, incl. short and shifting lengths",
			fields_sent, bytes_sent);
		$display("checked %0d results: ok %0d, short %0d, bad cookie %0d, overrun %0d",
			results_checked, status_count[dhcpo_pkg::ST_OK], status_count[dhcpo_pkg::ST_SHORT],
			status_count[dhcpo_pkg::ST_BAD_COOKIE], status_count[dhcpo_pkg::ST_OVERRUN]);
		if (mismatches == 0) begin
			$display("dhcp_option_tlv_parser_tb: clean");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("dhcp_option_tlv_parser_tb: errors");
		end
		$finish;
	end

endmodule
